[sv/hpm_pkg.sv]
package hpm_pkg;

    // register indexes of the coefficient bank
    localparam logic [2:0] REG_ROW0_AB    = 3'd0;
    localparam logic [2:0] REG_ROW0C_ROW1A = 3'd1;
    localparam logic [2:0] REG_ROW1_BC    = 3'd2;
    localparam logic [2:0] REG_ROW2_AB    = 3'd3;
    localparam logic [2:0] REG_ROW2_C     = 3'd4;

    // quotient bits resolved by the divider pipe
    localparam int QUOT_BITS = 17;

    // per-beat control travelling alongside the divider data
    typedef struct packed {
        logic valid;
        logic zero;
        logic neg0;
        logic neg1;
        logic ovf0;
        logic ovf1;
    } hpm_meta_t;

endpackage

[sv/hpm_mac.sv]
module hpm_mac
    import hpm_pkg::*;
#(
    parameter int CB = 12
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [31:0]    c_a,
    input  logic signed [31:0]    c_b,
    input  logic signed [31:0]    c_c,
    input  logic [CB-1:0]         y,
    input  logic [CB-1:0]         x,
    output logic signed [CB+34:0] sum
);

    localparam int PW = CB + 33;
    localparam int SW = CB + 35;

    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    logic signed [31:0]   c_c_reg;
    logic signed [SW-1:0] sum_reg, sum_next;

    // product stage
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_a_reg <= c_a * $signed({1'b0, y});
            prod_b_reg <= c_b * $signed({1'b0, x});
            c_c_reg    <= c_c;
        end
    end

    // accumulate stage
    always_comb begin
        sum_next = SW'(prod_a_reg) + SW'(prod_b_reg) + SW'(c_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

[sv/hpm_div_step.sv]
module hpm_div_step
    import hpm_pkg::*;
#(
    parameter int W   = 65,
    parameter int BIT = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [W-1:0]         d_in,
    input  logic [W-1:0]         r_in,
    input  logic [QUOT_BITS-1:0] q_in,
    output logic [W-1:0]         d_out,
    output logic [W-1:0]         r_out,
    output logic [QUOT_BITS-1:0] q_out
);

    logic [W-1:0]         trial;
    logic                 ge;
    logic [W-1:0]         d_reg, r_reg, r_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;

    // one restoring step: subtract the shifted divisor when it fits
    always_comb begin
        trial     = d_in << BIT;
        ge        = (r_in >= trial);
        r_next    = ge ? (r_in - trial) : r_in;
        q_next    = q_in;
        q_next[BIT] = ge;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_in;
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign d_out = d_reg;
    assign r_out = r_reg;
    assign q_out = q_reg;

endmodule

[sv/homography_point_map.sv]
// Homography point map: each beat (s_in_x, s_in_y) is multiplied as (y, x, 1) by a
// 3x3 signed Q12.20 matrix, and the first two dot products are divided by the
// third, rounded half away from zero and saturated to 16 bits. The block takes
// one beat per cycle through two multiply/accumulate stages, one sign and range
// stage, a 17-stage restoring divider (one quotient bit per stage) and the output
// register. The whole pipe stalls only while a result waits on m_ready. A zero
// denominator gives (-1, -1) with m_valid_res low;
// a clamped coordinate also drives m_valid_res low. Coefficients sit in five
// APB registers at 8-byte spacing and should be written while the pipe is empty.
module homography_point_map
    import hpm_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_in_x,
    input  logic [COORD_BITS-1:0] s_in_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_out_x,
    output logic signed [15:0]    m_out_y,
    output logic                  m_valid_res
);

    localparam int SW = COORD_BITS + 35;
    localparam int W  = SW + 18;
    localparam logic [63:0] ONE = 64'(1) << COEF_FRAC_BITS;

    logic [63:0] row0_ab_reg, row0c_row1a_reg, row1_bc_reg, row2_ab_reg;
    logic [31:0] row2_c_reg;
    logic        wr_en;
    logic        en;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_ab_reg     <= ONE << 32;
            row0c_row1a_reg <= '0;
            row1_bc_reg     <= ONE << 32;
            row2_ab_reg     <= '0;
            row2_c_reg      <= ONE[31:0];
        end else if (wr_en) begin
            case (paddr[5:3])
                REG_ROW0_AB:     row0_ab_reg     <= pwdata;
                REG_ROW0C_ROW1A: row0c_row1a_reg <= pwdata;
                REG_ROW1_BC:     row1_bc_reg     <= pwdata;
                REG_ROW2_AB:     row2_ab_reg     <= pwdata;
                REG_ROW2_C:      row2_c_reg      <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_ROW0_AB:     prdata = row0_ab_reg;
            REG_ROW0C_ROW1A: prdata = row0c_row1a_reg;
            REG_ROW1_BC:     prdata = row1_bc_reg;
            REG_ROW2_AB:     prdata = row2_ab_reg;
            REG_ROW2_C:      prdata = {32'd0, row2_c_reg};
            default:         prdata = '0;
        endcase
    end

    // pipe advances unless a result is held
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    // dot products
    logic signed [SW-1:0] n0, n1, dd;
    logic                 v1_reg, v2_reg;

    hpm_mac #(.CB(COORD_BITS)) u_mac0 (
        .aclk(aclk), .en(en),
        .c_a($signed(row0_ab_reg[63:32])), .c_b($signed(row0_ab_reg[31:0])),
        .c_c($signed(row0c_row1a_reg[63:32])),
        .y(s_in_y), .x(s_in_x), .sum(n0)
    );

    hpm_mac #(.CB(COORD_BITS)) u_mac1 (
        .aclk(aclk), .en(en),
        .c_a($signed(row0c_row1a_reg[31:0])), .c_b($signed(row1_bc_reg[63:32])),
        .c_c($signed(row1_bc_reg[31:0])),
        .y(s_in_y), .x(s_in_x), .sum(n1)
    );

    hpm_mac #(.CB(COORD_BITS)) u_mac2 (
        .aclk(aclk), .en(en),
        .c_a($signed(row2_ab_reg[63:32])), .c_b($signed(row2_ab_reg[31:0])),
        .c_c($signed(row2_c_reg)),
        .y(s_in_y), .x(s_in_x), .sum(dd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    // magnitudes, rounding offset and range check
    logic [SW-1:0]    an0, an1, ad;
    logic [W-1:0]     nn0, nn1, den;
    hpm_meta_t        prep_next;

    always_comb begin
        an0 = n0[SW-1] ? SW'(-n0) : SW'(n0);
        an1 = n1[SW-1] ? SW'(-n1) : SW'(n1);
        ad  = dd[SW-1] ? SW'(-dd) : SW'(dd);
        nn0 = (W'(an0) << 1) + W'(ad);
        nn1 = (W'(an1) << 1) + W'(ad);
        den = W'(ad) << 1;
        prep_next.valid = v2_reg;
        prep_next.zero  = (dd == '0);
        prep_next.neg0  = n0[SW-1] ^ dd[SW-1];
        prep_next.neg1  = n1[SW-1] ^ dd[SW-1];
        prep_next.ovf0  = (nn0 >= (den << QUOT_BITS));
        prep_next.ovf1  = (nn1 >= (den << QUOT_BITS));
    end

    logic [W-1:0]         d0_pipe [0:QUOT_BITS];
    logic [W-1:0]         d1_pipe [0:QUOT_BITS];
    logic [W-1:0]         r0_pipe [0:QUOT_BITS];
    logic [W-1:0]         r1_pipe [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q0_pipe [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q1_pipe [0:QUOT_BITS];
    hpm_meta_t            meta_reg [0:QUOT_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_pipe[0] <= den;
            d1_pipe[0] <= den;
            r0_pipe[0] <= nn0;
            r1_pipe[0] <= nn1;
            q0_pipe[0] <= '0;
            q1_pipe[0] <= '0;
        end
    end

    // control travels with the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QUOT_BITS; i++) meta_reg[i] <= '0;
        end else if (en) begin
            meta_reg[0] <= prep_next;
            for (int i = 1; i <= QUOT_BITS; i++) meta_reg[i] <= meta_reg[i-1];
        end
    end

    // restoring divider, most significant quotient bit first
    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
        hpm_div_step #(.W(W), .BIT(QUOT_BITS - 1 - k)) u_step0 (
            .aclk(aclk), .en(en),
            .d_in(d0_pipe[k]), .r_in(r0_pipe[k]), .q_in(q0_pipe[k]),
            .d_out(d0_pipe[k+1]), .r_out(r0_pipe[k+1]), .q_out(q0_pipe[k+1])
        );
        hpm_div_step #(.W(W), .BIT(QUOT_BITS - 1 - k)) u_step1 (
            .aclk(aclk), .en(en),
            .d_in(d1_pipe[k]), .r_in(r1_pipe[k]), .q_in(q1_pipe[k]),
            .d_out(d1_pipe[k+1]), .r_out(r1_pipe[k+1]), .q_out(q1_pipe[k+1])
        );
    end

    // sign, saturation and output register
    hpm_meta_t                 mt;
    logic [QUOT_BITS-1:0]      qa, qb, sa, sb;
    logic                      sat0, sat1;
    logic [15:0]               ox_next, oy_next;
    logic                      ok_next;
    logic                      out_valid_reg;
    logic [15:0]               out_x_reg, out_y_reg;
    logic                      out_res_reg;

    always_comb begin
        mt   = meta_reg[QUOT_BITS];
        qa   = q0_pipe[QUOT_BITS];
        qb   = q1_pipe[QUOT_BITS];
        sat0 = mt.ovf0 | (mt.neg0 ? (qa > QUOT_BITS'(32768)) : (qa > QUOT_BITS'(32767)));
        sat1 = mt.ovf1 | (mt.neg1 ? (qb > QUOT_BITS'(32768)) : (qb > QUOT_BITS'(32767)));
        sa   = mt.neg0 ? QUOT_BITS'(-qa) : qa;
        sb   = mt.neg1 ? QUOT_BITS'(-qb) : qb;
        if (mt.zero) begin
            ox_next = 16'hFFFF;
            oy_next = 16'hFFFF;
            ok_next = 1'b0;
        end else begin
            ox_next = sat0 ? (mt.neg0 ? 16'h8000 : 16'h7FFF) : sa[15:0];
            oy_next = sat1 ? (mt.neg1 ? 16'h8000 : 16'h7FFF) : sb[15:0];
            ok_next = ~(sat0 | sat1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= mt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_x_reg   <= ox_next;
            out_y_reg   <= oy_next;
            out_res_reg <= ok_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_x     = $signed(out_x_reg);
    assign m_out_y     = $signed(out_y_reg);
    assign m_valid_res = out_res_reg;

endmodule

[sv/hpm_checker.sv]
module hpm_checker
    import hpm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  pready,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic signed [15:0]    m_out_x,
    input logic signed [15:0]    m_out_y,
    input logic                  m_valid_res
);

    // a held result keeps its beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_valid_res))
        else $error("result beat changed while stalled");

    // input side only stalls while a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // register port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind homography_point_map hpm_checker u_hpm_checker (.*);
